// File: hw/rtl/quaternion_to_euler_assert.svh
// Assertion macros for the quaternion to Euler angle converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion_to_euler: same-cycle check failed");

// next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion_to_euler: next-cycle check failed");

`endif

// File: hw/rtl/qte_pkg.sv
// Shared widths, constants and helper functions for the quaternion to Euler
// converter. No dependencies.
package qte_pkg;

  localparam int QW                = 32;  // quaternion component width
  localparam int DW                = 36;  // sine / cosine term width, Q.30
  localparam int CW                = 38;  // CORDIC x / y width
  localparam int ZW                = 64;  // CORDIC angle width, Q.60
  localparam int ROOT_W            = 31;  // square root result width
  localparam int REM_W             = 61;  // square root radicand width
  localparam int SQ_STAGES         = 16;  // two root bits per stage
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int OW_WIDE           = 16;
  localparam int OW_PITCH          = 15;

  localparam logic signed [ZW-1:0] PI_Q60  = 64'sh3243F6A8885A308D;
  localparam logic signed [DW-1:0] ONE_Q30 = DW'(64'sd1 << 30);
  localparam logic signed [16:0]   ROLL_LIM  = 17'sd25736;
  localparam logic signed [16:0]   PITCH_LIM = 17'sd12868;

  // atan(2^-i) in Q.60 from the truncated Taylor series
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          sh;
    sum = '0;
    if (i == 0) begin
      sum = 64'(PI_Q60 >>> 2);
    end else if (i <= 60) begin
      for (int k = 0; k < 31; k++) begin
        sh = i * (2 * k + 1);
        if (sh <= 60) begin
          term = ((64'd1 << 60) >> sh) / 64'(2 * k + 1);
          if (k % 2 == 1) sum = sum - term;
          else            sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  // round a Q.60 angle to Q3.13 and clamp to +/- lim
  function automatic logic signed [16:0] to_q13(input logic signed [ZW-1:0] z,
                                                input logic signed [16:0] lim);
    logic signed [ZW-1:0] t;
    logic signed [16:0]   r;
    t = (z + (64'sd1 <<< 46)) >>> 47;
    r = t[16:0];
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

// File: hw/rtl/qte_front.sv
// Front end: component products, sine / cosine terms, pitch sine square and
// square root radicand over four register stages. Depends on qte_pkg.
module qte_front (
  input  logic                          clk,
  input  logic [3:0]                    en,
  input  logic signed [qte_pkg::QW-1:0] quat_w,
  input  logic signed [qte_pkg::QW-1:0] quat_x,
  input  logic signed [qte_pkg::QW-1:0] quat_y,
  input  logic signed [qte_pkg::QW-1:0] quat_z,
  output logic [qte_pkg::REM_W-1:0]     rem,
  output logic signed [qte_pkg::DW-1:0] sr,
  output logic signed [qte_pkg::DW-1:0] cr,
  output logic signed [qte_pkg::DW-1:0] sp,
  output logic signed [qte_pkg::DW-1:0] sy,
  output logic signed [qte_pkg::DW-1:0] cy,
  output logic                          sat
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [DW-1:0] sr;
    logic signed [DW-1:0] cr;
    logic signed [DW-1:0] sp;
    logic signed [DW-1:0] sy;
    logic signed [DW-1:0] cy;
    logic                 sat;
  } terms_t;

  logic signed [63:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;
  terms_t             t1_nxt, t1_r, t2_r, t3_r;
  logic [61:0]        sq_r;
  logic [REM_W-1:0]   rem_r;
  logic signed [30:0] sp31;

  function automatic logic signed [DW-1:0] tp(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 29;
    return s[DW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      wx_r <= quat_w * quat_x;
      yz_r <= quat_y * quat_z;
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      wy_r <= quat_w * quat_y;
      zx_r <= quat_z * quat_x;
      wz_r <= quat_w * quat_z;
      xy_r <= quat_x * quat_y;
      zz_r <= quat_z * quat_z;
    end
  end

  always_comb begin
    t1_nxt.sr  = tp(wx_r) + tp(yz_r);
    t1_nxt.cr  = ONE_Q30 - tp(xx_r) - tp(yy_r);
    t1_nxt.sp  = tp(wy_r) - tp(zx_r);
    t1_nxt.sy  = tp(wz_r) + tp(xy_r);
    t1_nxt.cy  = ONE_Q30 - tp(yy_r) - tp(zz_r);
    t1_nxt.sat = (t1_nxt.sp >= ONE_Q30) || (t1_nxt.sp <= -ONE_Q30);
  end

  assign sp31 = t1_r.sp[30:0];

  always_ff @(posedge clk) begin
    if (en[1]) t1_r <= t1_nxt;
    if (en[2]) begin
      t2_r <= t1_r;
      sq_r <= 62'(sp31 * sp31);
    end
    if (en[3]) begin
      t3_r  <= t2_r;
      rem_r <= (REM_W'(1) << 60) - sq_r[REM_W-1:0];
    end
  end

  assign rem = rem_r;
  assign sr  = t3_r.sr;
  assign cr  = t3_r.cr;
  assign sp  = t3_r.sp;
  assign sy  = t3_r.sy;
  assign cy  = t3_r.cy;
  assign sat = t3_r.sat;

endmodule

// File: hw/rtl/qte_isqrt.sv
// Pipelined integer square root, two root bits per stage, with a sideband
// word carried alongside. Depends on qte_pkg.
module qte_isqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                          clk,
  input  logic [qte_pkg::SQ_STAGES-1:0] en,
  input  logic [qte_pkg::REM_W-1:0]     rem_in,
  input  logic [SIDE_W-1:0]             side_in,
  output logic [qte_pkg::ROOT_W-1:0]    root_out,
  output logic [SIDE_W-1:0]             side_out
);
  import qte_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_st_t;

  sq_st_t            st_r   [SQ_STAGES];
  logic [SIDE_W-1:0] side_r [SQ_STAGES];

  // one restoring step for root bit k
  function automatic sq_st_t sq_step(input sq_st_t s, input int k);
    sq_st_t      o;
    logic [62:0] trial;
    o = s;
    if (k >= 0) begin
      trial = (63'(s.root) << (k + 1)) + (63'd1 << (2 * k));
      if (63'(s.rem) >= trial) begin
        o.rem  = REM_W'(63'(s.rem) - trial);
        o.root = s.root | (ROOT_W'(1) << k);
      end
    end
    return o;
  endfunction

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_st
    sq_st_t st_in, st_nxt;
    if (j == 0) begin : g_first
      assign st_in = '{rem: rem_in, root: '0};
    end else begin : g_next
      assign st_in = st_r[j-1];
    end
    assign st_nxt = sq_step(sq_step(st_in, ROOT_W - 1 - 2 * j), ROOT_W - 2 - 2 * j);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st_r[j]   <= st_nxt;
        side_r[j] <= (j == 0) ? side_in : side_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign root_out = st_r[SQ_STAGES-1].root;
  assign side_out = side_r[SQ_STAGES-1];

endmodule

// File: hw/rtl/qte_cordic.sv
// Vectoring CORDIC pipeline: a half-turn pre-rotation stage, then one stage
// per iteration. Returns the Q.60 angle. Depends on qte_pkg.
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic [STAGES:0]               en,
  input  logic signed [qte_pkg::CW-1:0] x_in,
  input  logic signed [qte_pkg::CW-1:0] y_in,
  output logic signed [qte_pkg::ZW-1:0] z_out
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_r [STAGES+1];
  logic signed [CW-1:0] y_r [STAGES+1];
  logic signed [ZW-1:0] z_r [STAGES+1];
  logic                 zero_r [STAGES+1];

  // turn a vector with negative x by a half turn
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= (y_in >= 0) ? PI_Q60 : -PI_Q60;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_it
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_pow2(s - 1));
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[s-1] >>> (s - 1);
    assign dy = x_r[s-1] >>> (s - 1);

    always_ff @(posedge clk) begin
      if (en[s]) begin
        zero_r[s] <= zero_r[s-1];
        if (y_r[s-1] >= 0) begin
          x_r[s] <= x_r[s-1] + dx;
          y_r[s] <= y_r[s-1] - dy;
          z_r[s] <= z_r[s-1] + ANG;
        end else begin
          x_r[s] <= x_r[s-1] - dx;
          y_r[s] <= y_r[s-1] + dy;
          z_r[s] <= z_r[s-1] - ANG;
        end
      end
    end
  end

  // zero vector gives angle zero
  assign z_out = zero_r[STAGES] ? '0 : z_r[STAGES];

endmodule

// File: hw/rtl/quaternion_to_euler.sv
// Quaternion to Euler angle converter, top level.
// Channels: in_valid / in_ready take one quaternion word (Q2.30 w, x, y, z);
//   out_valid / out_ready deliver one word of roll and yaw (Q3.13 radians),
//   pitch (Q2.13 radians) and the pitch saturation flag.
// Pipeline: four front stages (products, terms, square, radicand),
//   16 square root stages, one pre-rotation and CORDIC_STAGES iteration
//   stages, one rounding stage.
// Throughput: one word per cycle while out_ready is high; each stage holds
//   one word and the roll, pitch and yaw CORDIC pipelines run side by side.
// Stall: each stage holds while it is full and the stage after it holds, so
//   bubbles close up and in_ready falls only once every stage is full.
// Reset: rst_n (synchronous, active low) clears all stage valid bits; data
//   registers are not reset.
// Depends on qte_pkg, qte_front, qte_isqrt, qte_cordic and the assertion
//   header.
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qte_pkg::QW-1:0]       in_quat_w,
  input  logic signed [qte_pkg::QW-1:0]       in_quat_x,
  input  logic signed [qte_pkg::QW-1:0]       in_quat_y,
  input  logic signed [qte_pkg::QW-1:0]       in_quat_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qte_pkg::OW_WIDE-1:0]  out_roll_angle,
  output logic signed [qte_pkg::OW_PITCH-1:0] out_pitch_angle,
  output logic signed [qte_pkg::OW_WIDE-1:0]  out_yaw_angle,
  output logic                                out_pitch_saturated
);
  import qte_pkg::*;

  localparam int SQ_BASE = 4;
  localparam int CD_BASE = SQ_BASE + SQ_STAGES;
  localparam int NST     = CD_BASE + CORDIC_STAGES + 2;
  localparam int SIDE_W  = 5 * DW + 1;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic [REM_W-1:0]  f_rem;
  logic signed [DW-1:0] f_sr, f_cr, f_sp, f_sy, f_cy;
  logic              f_sat;
  logic [ROOT_W-1:0] q_root;
  logic [SIDE_W-1:0] q_side;
  logic signed [DW-1:0] q_sr, q_cr, q_sp, q_sy, q_cy;
  logic              q_sat;
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
  logic              sat_r [CORDIC_STAGES+1];

  logic signed [OW_WIDE-1:0]  roll_r, yaw_r;
  logic signed [OW_PITCH-1:0] pitch_r;
  logic                       psat_r;
  logic signed [16:0]         pitch_q;

  // a stage advances when empty or when the stage after it advances
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  qte_front u_front (
    .clk    (clk),
    .en     (en[3:0]),
    .quat_w (in_quat_w),
    .quat_x (in_quat_x),
    .quat_y (in_quat_y),
    .quat_z (in_quat_z),
    .rem    (f_rem),
    .sr     (f_sr),
    .cr     (f_cr),
    .sp     (f_sp),
    .sy     (f_sy),
    .cy     (f_cy),
    .sat    (f_sat)
  );

  qte_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
    .clk      (clk),
    .en       (en[SQ_BASE +: SQ_STAGES]),
    .rem_in   (f_rem),
    .side_in  ({f_sr, f_cr, f_sp, f_sy, f_cy, f_sat}),
    .root_out (q_root),
    .side_out (q_side)
  );

  assign {q_sr, q_cr, q_sp, q_sy, q_cy, q_sat} = q_side;

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .en    (en[CD_BASE +: CORDIC_STAGES + 1]),
    .x_in  (CW'(q_cr)),
    .y_in  (CW'(q_sr)),
    .z_out (z_roll)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .en    (en[CD_BASE +: CORDIC_STAGES + 1]),
    .x_in  (CW'(signed'({1'b0, q_root}))),
    .y_in  (CW'(q_sp)),
    .z_out (z_pitch)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .en    (en[CD_BASE +: CORDIC_STAGES + 1]),
    .x_in  (CW'(q_cy)),
    .y_in  (CW'(q_sy)),
    .z_out (z_yaw)
  );

  // carry the saturation flag alongside the CORDIC stages
  for (genvar s = 0; s <= CORDIC_STAGES; s++) begin : g_sat
    always_ff @(posedge clk) begin
      if (en[CD_BASE + s]) sat_r[s] <= (s == 0) ? q_sat : sat_r[(s == 0) ? 0 : s - 1];
    end
  end

  // pitch sine delayed with the CORDIC; its sign sets pitch when saturated
  logic signed [DW-1:0] sp_d_r [CORDIC_STAGES+1];
  for (genvar s = 0; s <= CORDIC_STAGES; s++) begin : g_sp
    always_ff @(posedge clk) begin
      if (en[CD_BASE + s]) sp_d_r[s] <= (s == 0) ? q_sp : sp_d_r[(s == 0) ? 0 : s - 1];
    end
  end

  assign pitch_q = sat_r[CORDIC_STAGES]
                 ? ((sp_d_r[CORDIC_STAGES] > 0) ? PITCH_LIM : -PITCH_LIM)
                 : to_q13(z_pitch, PITCH_LIM);

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      roll_r  <= OW_WIDE'(to_q13(z_roll, ROLL_LIM));
      yaw_r   <= OW_WIDE'(to_q13(z_yaw, ROLL_LIM));
      pitch_r <= pitch_q[OW_PITCH-1:0];
      psat_r  <= sat_r[CORDIC_STAGES];
    end
  end

  assign in_ready            = en[0];
  assign out_valid           = v_r[NST-1];
  assign out_roll_angle      = roll_r;
  assign out_pitch_angle     = pitch_r;
  assign out_yaw_angle       = yaw_r;
  assign out_pitch_saturated = psat_r;

`include "quaternion_to_euler_assert.svh"

  `QTE_ASSERT_NOW(a_sat_pitch, out_valid && out_pitch_saturated,
    out_pitch_angle == 15'sd12868 || out_pitch_angle == -15'sd12868)
  `QTE_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)
  `QTE_ASSERT_NEXT(a_hold_full, out_valid && !out_ready, out_valid && $stable(out_roll_angle))

endmodule

// File: sim/tb_quaternion_to_euler.sv
// Testbench for quaternion_to_euler: drives quaternion words and checks each result
// word against a bit-exact predictor of the rounding, square root and CORDIC math.
// Depends on qte_pkg and the quaternion_to_euler RTL.
module tb_quaternion_to_euler;
  import qte_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam longint ONE = 64'sd1 << 30;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic signed [OW_WIDE-1:0]  roll;
    logic signed [OW_PITCH-1:0] pitch;
    logic signed [OW_WIDE-1:0]  yaw;
    logic                       sat;
  } angles_t;

  typedef struct {
    int      w, x, y, z;
    bit      known;
    angles_t ang;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [QW-1:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OW_WIDE-1:0]  out_roll_angle, out_yaw_angle;
  logic signed [OW_PITCH-1:0] out_pitch_angle;
  logic out_pitch_saturated;

  angles_t pending_angles[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_cycles = 0;

  quaternion_to_euler #(.CORDIC_STAGES(STAGES)) u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint twice_mul(longint a, longint b);
    return (a * b) >>> 29;
  endfunction

  function automatic longint arctan_step(int i);
    longint unsigned acc, term;
    if (i == 0) return PI_Q60 >>> 2;
    acc = 0;
    for (int k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        term = ((64'd1 << 60) >> (i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
    end
    return longint'(acc);
  endfunction

  function automatic longint vector_angle(longint ys, longint xs);
    longint ang, dx, dy;
    ang = 0;
    if (xs == 0 && ys == 0) return 0;
    // turn by pi when the cosine is negative
    if (xs < 0) begin
      ang = (ys >= 0) ? PI_Q60 : -PI_Q60;
      xs = -xs;
      ys = -ys;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs += dx; ys -= dy; ang += arctan_step(i);
      end else begin
        xs -= dx; ys += dy; ang -= arctan_step(i);
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint round_q13(longint ang, longint lim);
    longint r;
    r = (ang + (64'sd1 <<< 46)) >>> 47;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(int qw, int qx, int qy, int qz);
    angles_t res;
    longint w, x, y, z, sr, cr, sp, sy, cy, c;
    w = qw; x = qx; y = qy; z = qz;
    sr = twice_mul(w, x) + twice_mul(y, z);
    cr = ONE - twice_mul(x, x) - twice_mul(y, y);
    sp = twice_mul(w, y) - twice_mul(z, x);
    sy = twice_mul(w, z) + twice_mul(x, y);
    cy = ONE - twice_mul(y, y) - twice_mul(z, z);
    res.roll = OW_WIDE'(round_q13(vector_angle(sr, cr), 25736));
    res.yaw  = OW_WIDE'(round_q13(vector_angle(sy, cy), 25736));
    if (sp >= ONE || sp <= -ONE) begin
      res.pitch = (sp > 0) ? 15'sd12868 : -15'sd12868;
      res.sat = 1'b1;
    end else begin
      c = longint'(int_sqrt((64'd1 << 60) - longint'(sp * sp)));
      res.pitch = OW_PITCH'(round_q13(vector_angle(sp, c), 12868));
      res.sat = 1'b0;
    end
    return res;
  endfunction

  // ---------------- driving ----------------
  task automatic send_word(int w, int x, int y, int z, bit known, angles_t ang);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_w <= w;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_angles.push_back(known ? ang : euler_of(w, x, y, z));
  endtask

  function automatic int clip_q30(longint v);
    if (v > ONE) return int'(ONE);
    if (v < -ONE) return int'(-ONE);
    return int'(v);
  endfunction

  function automatic int any_q30();
    return int'(longint'($urandom_range(32'h8000_0000, 0)) - ONE);
  endfunction

  task automatic send_random();
    real a[4];
    real n;
    int  q[4];
    int  kind;
    kind = $urandom_range(99, 0);
    if (kind < 70) begin
      // unit quaternion, random direction
      n = 0.0;
      foreach (a[i]) begin
        a[i] = real'(int'($urandom_range(2000000, 0)) - 1000000);
        n += a[i] * a[i];
      end
      if (n == 0.0) begin a[0] = 1.0; n = 1.0; end
      n = $sqrt(n);
      foreach (q[i]) q[i] = clip_q30(longint'($rtoi(a[i] / n * 1073741824.0)));
    end else if (kind < 85) begin
      // near gimbal lock
      q[0] = 759250125 + int'($urandom_range(4000, 0)) - 2000;
      q[2] = ($urandom_range(1, 0) ? 1 : -1) * (759250125 + int'($urandom_range(4000, 0)) - 2000);
      q[1] = int'($urandom_range(2000, 0)) - 1000;
      q[3] = int'($urandom_range(2000, 0)) - 1000;
    end else begin
      foreach (q[i]) q[i] = any_q30();
    end
    send_word(q[0], q[1], q[2], q[3], 1'b0, '0);
  endtask

  task automatic drain();
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // ---------------- receiving and checking ----------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    angles_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word roll=%0d", out_roll_angle);
      end else begin
        exp_a = pending_angles.pop_front();
        if (exp_a.roll !== out_roll_angle || exp_a.pitch !== out_pitch_angle ||
            exp_a.yaw !== out_yaw_angle || exp_a.sat !== out_pitch_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r=%0d p=%0d y=%0d s=%0b got r=%0d p=%0d y=%0d s=%0b",
                     exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.sat, out_roll_angle,
                     out_pitch_angle, out_yaw_angle, out_pitch_saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  vector_row_t vectors[] = '{
    '{1073741824, 0, 0, 0, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{0, 0, 0, 0, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{0, 1073741824, 0, 0, 1'b1, '{16'sd25736, 15'sd0, 16'sd0, 1'b0}},
    '{1073741824, 0, 1073741824, 0, 1'b1, '{16'sd25736, 15'sd12868, 16'sd25736, 1'b1}},
    '{1073741824, 0, -1073741824, 0, 1'b1, '{16'sd25736, -15'sd12868, 16'sd25736, 1'b1}},
    '{0, 536870912, 536870912, 0, 1'b0, '0},
    '{-1073741824, -1073741824, -1073741824, -1073741824, 1'b0, '0},
    '{1073741824, 1073741824, 1073741824, 1073741824, 1'b0, '0},
    '{-1073741824, 1073741824, -1073741824, 1073741824, 1'b0, '0},
    '{0, 0, 0, 1073741824, 1'b0, '0},
    '{0, 0, 1073741824, 0, 1'b0, '0},
    '{759250125, 759250125, 0, 0, 1'b0, '0},
    '{759250125, -759250125, 0, 0, 1'b0, '0},
    '{759250125, 0, 0, 759250125, 1'b0, '0},
    '{759250125, 0, 0, -759250125, 1'b0, '0},
    '{0, -759250125, 0, 759250125, 1'b0, '0},
    '{759250125, 0, 759250124, 0, 1'b0, '0},
    '{536870912, 536870912, 536870912, 536870912, 1'b0, '0},
    '{-536870912, 536870912, -536870912, 536870912, 1'b0, '0},
    '{1, -1, 1, -1, 1'b0, '0}
  };

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i])
      send_word(vectors[i].w, vectors[i].x, vectors[i].y, vectors[i].z,
                vectors[i].known, vectors[i].ang);

    repeat (70) send_random();
    idle_pct = 46;
    repeat (70) send_random();
    idle_pct = 0; stall_pct = 46;
    repeat (70) send_random();
    idle_pct = 8; stall_pct = 8;
    repeat (70) send_random();

    // hold the output long enough for the pipeline to fill and back up
    idle_pct = 0; stall_pct = 0;
    hold_cycles = 200;
    repeat (60) send_random();
    in_valid <= 1'b0;
    @(posedge clk);
    drain();
    repeat (60) send_random();

    in_valid <= 1'b0;
    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
